FILE: hw/rtl/mks_pkg.sv
// shared widths and the entry type for the morton key sorter
`timescale 1ns / 1ps

package mks_pkg;

  localparam int POS_W   = 12;
  localparam int TAG_W   = 16;
  localparam int KEY_W   = 29;
  localparam int COORD_W = 10;

  // scaling_mode register codes
  typedef enum logic {
    SCALE_DIRECT   = 1'b0,
    SCALE_CENTERED = 1'b1
  } scale_mode_t;

  // one stored body: valid flag, morton key and tag
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

FILE: hw/rtl/mks_if.sv
// valid/ready channel interfaces for bodies in and sorted results out
`timescale 1ns / 1ps

interface mks_body_if;
  logic                              valid;
  logic                              ready;
  logic signed [mks_pkg::POS_W-1:0]  pos_x;
  logic signed [mks_pkg::POS_W-1:0]  pos_y;
  logic        [mks_pkg::TAG_W-1:0]  body_tag;
  logic                              last_body;

  modport source (output valid, pos_x, pos_y, body_tag, last_body, input ready);
  modport sink   (input valid, pos_x, pos_y, body_tag, last_body, output ready);
endinterface

interface mks_result_if;
  logic                       valid;
  logic                       ready;
  logic [mks_pkg::TAG_W-1:0]  sorted_tag;
  logic [mks_pkg::KEY_W-1:0]  sort_key;
  logic                       last_sorted;

  modport source (output valid, sorted_tag, sort_key, last_sorted, input ready);
  modport sink   (input valid, sorted_tag, sort_key, last_sorted, output ready);
endinterface

FILE: hw/rtl/mks_keygen.sv
// quantizes a body position to cells and interleaves them into a morton key
`timescale 1ns / 1ps

module mks_keygen #(
  parameter int CELL_BITS = 10
) (
  input  logic                              scaling_mode,
  input  logic signed [mks_pkg::POS_W-1:0]  pos_x,
  input  logic signed [mks_pkg::POS_W-1:0]  pos_y,
  output logic        [mks_pkg::KEY_W-1:0]  key
);

  localparam logic [mks_pkg::POS_W-1:0] MaxCell =
    mks_pkg::POS_W'((1 << CELL_BITS) - 1);

  logic [mks_pkg::COORD_W-1:0] cell_x;
  logic [mks_pkg::COORD_W-1:0] cell_y;

  // raw or centered scaling, negative to zero, clamp to top cell
  function automatic logic [mks_pkg::COORD_W-1:0] to_cell(
    input logic                             mode,
    input logic signed [mks_pkg::POS_W-1:0] raw
  );
    logic signed [mks_pkg::POS_W:0] ctr;
    logic        [mks_pkg::POS_W-1:0] u;
    ctr = {raw[mks_pkg::POS_W-1], raw} + (mks_pkg::POS_W+1)'(1024);
    if (mode == mks_pkg::SCALE_CENTERED) begin
      u = ctr[mks_pkg::POS_W] ? '0 : {1'b0, ctr[mks_pkg::POS_W-1:1]};
    end else begin
      u = raw[mks_pkg::POS_W-1] ? '0 : raw;
    end
    if (u > MaxCell) u = MaxCell;
    return u[mks_pkg::COORD_W-1:0];
  endfunction

  assign cell_x = to_cell(scaling_mode, pos_x);
  assign cell_y = to_cell(scaling_mode, pos_y);

  // x bits on every third position, y bits one above
  always_comb begin
    key = '0;
    for (int i = 0; i < mks_pkg::COORD_W; i++) begin
      key[3*i]   = cell_x[i];
      key[3*i+1] = cell_y[i];
    end
  end

endmodule

FILE: hw/rtl/mks_cell.sv
// one insertion-sort cell: holds one entry, takes the new key or its neighbor's
`timescale 1ns / 1ps

module mks_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            ins,
  input  logic            shift,
  input  mks_pkg::entry_t new_ent,
  input  mks_pkg::entry_t prev_ent,
  input  logic            prev_gt,
  input  mks_pkg::entry_t next_ent,
  output mks_pkg::entry_t ent,
  output logic            gt
);

  mks_pkg::entry_t take;

  // empty cells count as larger, so a key above all stored keys lands in the first free cell
  assign gt   = !ent.valid || (ent.key > new_ent.key);
  assign take = prev_gt ? prev_ent : new_ent;

  // entry register, only the valid flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (shift) begin
      ent <= next_ent;
    end else if (ins && gt) begin
      ent <= take;
    end
  end

endmodule

FILE: hw/rtl/morton_key_sorter_top.sv
// top level of the morton key sorter: key generation, cell chain, output drain
`timescale 1ns / 1ps

// Bodies are taken one per cycle while no output run is under way; each is
// turned into a 29-bit Morton key and placed by a chain of MAX_BODIES cells
// in the same cycle it is accepted. The request flagged last_body starts the
// output run: from the next cycle the chain shifts toward its head and gives
// one result per cycle while the sink keeps ready high, in ascending key
// order with equal keys in arrival order. No body is taken while the run is
// being delivered. A body arriving with all cells full is dropped.
// scaling_mode may only be written while the block is idle.
module morton_key_sorter_top #(
  parameter int MAX_BODIES = 64,
  parameter int CELL_BITS  = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  mks_body_if.sink            body_in,
  mks_result_if.source        result_out
);

  logic                       scaling_mode;
  logic                       draining;
  logic [mks_pkg::KEY_W-1:0]  new_key;
  mks_pkg::entry_t            new_ent;
  mks_pkg::entry_t            ent [MAX_BODIES];
  logic [MAX_BODIES-1:0]      gt;
  logic [MAX_BODIES-1:0]      vld;
  logic                       body_acc;
  logic                       ins;
  logic                       shift;
  logic                       full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scaling_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      scaling_mode <= cfg_wr_data;
    end
  end

  // key generation
  mks_keygen #(.CELL_BITS(CELL_BITS)) u_keygen (
    .scaling_mode (scaling_mode),
    .pos_x        (body_in.pos_x),
    .pos_y        (body_in.pos_y),
    .key          (new_key)
  );

  assign new_ent = '{valid: 1'b1, key: new_key, tag: body_in.body_tag};

  // handshake control
  assign full     = ent[MAX_BODIES-1].valid;
  assign body_acc = body_in.valid && body_in.ready;
  assign ins      = body_acc && !full;
  assign shift    = result_out.valid && result_out.ready;

  assign body_in.ready = !draining;

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (body_acc && body_in.last_body) begin
      draining <= 1'b1;
    end else if (shift && result_out.last_sorted) begin
      draining <= 1'b0;
    end
  end

  // chain of cells, head at index 0
  for (genvar i = 0; i < MAX_BODIES; i++) begin : g_cell
    mks_pkg::entry_t prev_ent;
    mks_pkg::entry_t next_ent;
    logic            prev_gt;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == MAX_BODIES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = ent[i+1];
    end

    mks_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ins      (ins),
      .shift    (shift),
      .new_ent  (new_ent),
      .prev_ent (prev_ent),
      .prev_gt  (prev_gt),
      .next_ent (next_ent),
      .ent      (ent[i]),
      .gt       (gt[i])
    );

    assign vld[i] = ent[i].valid;
  end

  // results come straight from the head cell
  assign result_out.valid       = draining;
  assign result_out.sorted_tag  = ent[0].tag;
  assign result_out.sort_key    = ent[0].key;
  assign result_out.last_sorted = !ent[1].valid;

  // occupied cells always form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((vld >> 1) & ~vld) == '0)
    else $error("gap in occupied cells");

  // head of the chain never holds a larger key than its neighbor
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    (ent[0].valid && ent[1].valid) |-> (ent[0].key <= ent[1].key))
    else $error("head cells out of order");

  // the last body always leaves at least one result to deliver
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (body_acc && body_in.last_body) |=> (result_out.valid && ent[0].valid))
    else $error("output run did not start");

  // after the final result the chain is empty
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (shift && result_out.last_sorted) |=> (vld == '0))
    else $error("cells left after final result");

endmodule
